// ===== src/ffpt_pkg.sv =====
package ffpt_pkg;

	// frame layout
	localparam int HEX_DIGITS = 6;
	localparam int POS_W      = 4;
	localparam int RAW_W      = 24;
	localparam int SENS_W     = 24;
	localparam int FORCE_W    = 32;
	localparam int PROD_W     = RAW_W + SENS_W;
	localparam int FRAC_W     = 16;

	localparam logic [POS_W-1:0] POS_ZERO  = POS_W'(HEX_DIGITS);
	localparam logic [POS_W-1:0] POS_TAG   = POS_W'(HEX_DIGITS + 1);
	localparam logic [POS_W-1:0] POS_CR    = POS_W'(HEX_DIGITS + 2);
	localparam logic [POS_W-1:0] FRAME_END = POS_W'(HEX_DIGITS + 3);

	// ascii codes
	localparam logic [7:0] ASC_ZERO  = 8'h30;
	localparam logic [7:0] ASC_NINE  = 8'h39;
	localparam logic [7:0] ASC_LA    = 8'h61;
	localparam logic [7:0] ASC_LF_HI = 8'h66;
	localparam logic [7:0] ASC_UA    = 8'h41;
	localparam logic [7:0] ASC_UF    = 8'h46;
	localparam logic [7:0] ASC_TAG1  = 8'h62;
	localparam logic [7:0] ASC_TAG2  = 8'h64;
	localparam logic [7:0] ASC_CR    = 8'h0d;
	localparam logic [7:0] ASC_LF    = 8'h0a;

	// configuration register indexes
	localparam logic CFG_SENS_CH1 = 1'b0;
	localparam logic CFG_SENS_CH2 = 1'b1;
	localparam logic [SENS_W-1:0] SENS_RESET = 24'd65536;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FRAME = 2'd1,
		ST_HEX   = 2'd2
	} status_t;

	localparam logic [1:0] CH_NONE = 2'd0;
	localparam logic [1:0] CH_1    = 2'd1;
	localparam logic [1:0] CH_2    = 2'd2;

	// parsed frame, handed from parser to scaler
	typedef struct packed {
		status_t           status;
		logic [1:0]        channel;
		logic [RAW_W-1:0]  raw;
		logic              neg;
		logic [RAW_W-1:0]  mag;
		logic              cap;
	} frame_t;

	// finished result
	typedef struct packed {
		status_t            status;
		logic [1:0]         channel;
		logic [RAW_W-1:0]   raw;
		logic [FORCE_W-1:0] abs_force;
		logic [FORCE_W-1:0] rel_force;
		logic               cap;
	} result_t;

endpackage

// ===== src/force_frame_parser_tare_top.sv =====
// channel  dir  beat contents
// s_*      in   tdata[7:0] rx_byte
// m_*      out  tuser frame_status, channel; tdata raw, absolute, relative, zero flag
// cfg_*    in   cfg_index selects sens_ch1 or sens_ch2, cfg_data the 24-bit value
//
// one byte beat per cycle is taken while s_tready is high; every LF beat yields one result
// beat through the parser register, multiply register and output register
// other bytes only advance the frame parser and give no result
// arst_n clears the parser, reference zeros and capture flags; sensitivities go to 1.0
// a stalled m_tready holds the pipe stage by stage; s_tready drops only when all
// three stages are full
module force_frame_parser_tare_top import ffpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,    // [23:0] raw_value, [55:24] absolute_force,
	                                // [87:56] relative_force, [88] zero_captured, rest zero
	output logic [3:0]  m_tuser,    // [1:0] frame_status, [3:2] channel
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);

	logic [SENS_W-1:0] sens_ch1_q;
	logic [SENS_W-1:0] sens_ch2_q;

	logic    frame_v_s1;
	frame_t  frame_s1;
	logic    scale_ready;
	logic    adv;
	result_t res;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_ch1_q <= SENS_RESET;
			sens_ch2_q <= SENS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SENS_CH1: sens_ch1_q <= cfg_data;
				CFG_SENS_CH2: sens_ch2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage one moves when it is empty or the scaler takes its frame
	assign adv      = !frame_v_s1 || scale_ready;
	assign s_tready = adv;

	ffpt_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid),
		.rx_byte    (s_tdata),
		.adv        (adv),
		.frame_v_s1 (frame_v_s1),
		.frame_s1   (frame_s1)
	);

	ffpt_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_v     (frame_v_s1),
		.frame       (frame_s1),
		.frame_ready (scale_ready),
		.sens_ch1    (sens_ch1_q),
		.sens_ch2    (sens_ch2_q),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_q       (res)
	);

	// pack result beat, lowest field first
	assign m_tdata = {7'd0, res.cap, res.rel_force, res.abs_force, res.raw};
	assign m_tuser = {res.channel, res.status};

endmodule

// ===== src/ffpt_parser.sv =====
module ffpt_parser import ffpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic [7:0]       rx_byte,
	input  logic             adv,
	output logic             frame_v_s1,
	output frame_t           frame_s1
);

	logic [POS_W-1:0] pos_q;
	logic [RAW_W-1:0] acc_q;
	logic             hex_err_q;
	logic             fmt_err_q;
	logic [1:0]       tag_q;
	logic [RAW_W-1:0] ref_q [2];
	logic             taken_q [2];

	logic             accept;
	logic             is_lf;
	logic             digit_ok;
	logic [3:0]       digit;
	logic [POS_W-1:0] pos_d;
	logic [RAW_W-1:0] acc_d;
	logic             hex_err_d;
	logic             fmt_err_d;
	logic [1:0]       tag_d;
	status_t          status;
	logic             k;
	logic             cap;
	logic [RAW_W-1:0] ref_eff;
	logic [RAW_W:0]   diff;
	logic [RAW_W:0]   ndiff;
	frame_t           frame_d;

	assign accept = byte_valid && adv;
	assign is_lf  = (rx_byte == ASC_LF);

	// hex digit decode, either case
	always_comb begin
		digit_ok = 1'b1;
		digit    = 4'd0;
		if (rx_byte >= ASC_ZERO && rx_byte <= ASC_NINE) begin
			digit = 4'(rx_byte - ASC_ZERO);
		end else if (rx_byte >= ASC_LA && rx_byte <= ASC_LF_HI) begin
			digit = 4'(rx_byte - ASC_LA + 8'd10);
		end else if (rx_byte >= ASC_UA && rx_byte <= ASC_UF) begin
			digit = 4'(rx_byte - ASC_UA + 8'd10);
		end else begin
			digit_ok = 1'b0;
		end
	end

	// field sequencing for non-LF bytes
	always_comb begin
		pos_d     = pos_q;
		acc_d     = acc_q;
		hex_err_d = hex_err_q;
		fmt_err_d = fmt_err_q;
		tag_d     = tag_q;
		if (pos_q < POS_ZERO) begin
			if (!digit_ok) hex_err_d = 1'b1;
			else acc_d = {acc_q[RAW_W-5:0], digit};
		end else if (pos_q == POS_ZERO) begin
			if (rx_byte != ASC_ZERO) fmt_err_d = 1'b1;
		end else if (pos_q == POS_TAG) begin
			if (rx_byte == ASC_TAG1) tag_d = CH_1;
			else if (rx_byte == ASC_TAG2) tag_d = CH_2;
			else fmt_err_d = 1'b1;
		end else if (pos_q == POS_CR) begin
			if (rx_byte != ASC_CR) fmt_err_d = 1'b1;
		end else begin
			fmt_err_d = 1'b1;
		end
		if (pos_q < FRAME_END) pos_d = pos_q + POS_W'(1);
	end

	// end of frame: status, reference capture, difference
	always_comb begin
		if (pos_q != FRAME_END || fmt_err_q || tag_q == CH_NONE) status = ST_FRAME;
		else if (hex_err_q) status = ST_HEX;
		else status = ST_OK;
		k       = (tag_q == CH_2);
		cap     = (status == ST_OK) && !taken_q[k] && (acc_q != '0);
		ref_eff = cap ? acc_q : ref_q[k];
		diff    = {1'b0, acc_q} - {1'b0, ref_eff};
		ndiff   = -diff;
		frame_d.status  = status;
		frame_d.channel = tag_q;
		frame_d.cap     = cap;
		if (status == ST_OK) begin
			frame_d.raw = acc_q;
			frame_d.neg = diff[RAW_W];
			frame_d.mag = diff[RAW_W] ? ndiff[RAW_W-1:0] : diff[RAW_W-1:0];
		end else begin
			frame_d.raw = '0;
			frame_d.neg = 1'b0;
			frame_d.mag = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			acc_q      <= '0;
			hex_err_q  <= 1'b0;
			fmt_err_q  <= 1'b0;
			tag_q      <= CH_NONE;
			ref_q[0]   <= '0;
			ref_q[1]   <= '0;
			taken_q[0] <= 1'b0;
			taken_q[1] <= 1'b0;
		end else if (accept) begin
			if (is_lf) begin
				pos_q     <= '0;
				acc_q     <= '0;
				hex_err_q <= 1'b0;
				fmt_err_q <= 1'b0;
				tag_q     <= CH_NONE;
				if (cap) begin
					ref_q[k]   <= acc_q;
					taken_q[k] <= 1'b1;
				end
			end else begin
				pos_q     <= pos_d;
				acc_q     <= acc_d;
				hex_err_q <= hex_err_d;
				fmt_err_q <= fmt_err_d;
				tag_q     <= tag_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_s1 <= 1'b0;
		end else if (adv) begin
			frame_v_s1 <= accept && is_lf;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_lf) frame_s1 <= frame_d;
	end

endmodule

// ===== src/ffpt_scale.sv =====
module ffpt_scale import ffpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_v,
	input  frame_t            frame,
	output logic              frame_ready,
	input  logic [SENS_W-1:0] sens_ch1,
	input  logic [SENS_W-1:0] sens_ch2,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res_q
);

	logic               v_s2;
	status_t            status_s2;
	logic [1:0]         channel_s2;
	logic [RAW_W-1:0]   raw_s2;
	logic               neg_s2;
	logic               cap_s2;
	logic [PROD_W-1:0]  prod_abs_s2;
	logic [PROD_W-1:0]  prod_rel_s2;

	logic               out_take;
	logic               s2_en;
	logic [SENS_W-1:0]  sens;
	logic [FORCE_W-1:0] abs_full;
	logic [FORCE_W-1:0] rel_mag;
	logic [FORCE_W-1:0] rel_sat;
	result_t            res_d;

	assign out_take    = !res_valid || res_ready;
	assign s2_en       = !v_s2 || out_take;
	assign frame_ready = s2_en;

	assign sens = (frame.channel == CH_2) ? sens_ch2 : sens_ch1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (s2_en) v_s2 <= frame_v;
			if (out_take) res_valid <= v_s2;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (s2_en && frame_v) begin
			status_s2   <= frame.status;
			channel_s2  <= frame.channel;
			raw_s2      <= frame.raw;
			neg_s2      <= frame.neg;
			cap_s2      <= frame.cap;
			prod_abs_s2 <= frame.raw * sens;
			prod_rel_s2 <= frame.mag * sens;
		end
	end

	// drop fraction, saturate
	always_comb begin
		abs_full = prod_abs_s2[FRAC_W +: FORCE_W];
		rel_mag  = prod_rel_s2[FRAC_W +: FORCE_W];
		if (!neg_s2) begin
			rel_sat = (rel_mag > 32'h7fff_ffff) ? 32'h7fff_ffff : rel_mag;
		end else begin
			rel_sat = (rel_mag > 32'h8000_0000) ? 32'h8000_0000 : rel_mag;
			rel_sat = -rel_sat;
		end
		res_d.status    = status_s2;
		res_d.channel   = channel_s2;
		res_d.raw       = raw_s2;
		res_d.abs_force = abs_full;
		res_d.rel_force = rel_sat;
		res_d.cap       = cap_s2;
	end

	always_ff @(posedge clk) begin
		if (out_take && v_s2) res_q <= res_d;
	end

endmodule

// ===== sim/tb_force_frame_parser_tare_top.sv =====
module tb_force_frame_parser_tare_top import ffpt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;     // [23:0] raw_value, [55:24] absolute_force,
	                          // [87:56] relative_force, [88] zero_captured
	logic [3:0]  m_tuser;     // [1:0] frame_status, [3:2] channel
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [23:0] cfg_data;

	force_frame_parser_tare_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the parser and tare state, all cleared by the one reset
	logic [3:0]  pr_pos   = '0;
	logic [23:0] pr_acc   = '0;
	logic        pr_herr  = 1'b0;
	logic        pr_ferr  = 1'b0;
	logic [1:0]  pr_tag   = CH_NONE;
	logic [23:0] pr_ref   [2] = '{24'd0, 24'd0};
	logic        pr_taken [2] = '{1'b0, 1'b0};
	logic [23:0] sens_of  [2] = '{SENS_RESET, SENS_RESET};

	// results owed by the block, oldest first
	result_t results_due [$];
	int      mismatches = 0;

	// idle stretches: while quiet, that side never idles
	bit src_quiet = 1'b0;
	bit snk_quiet = 1'b0;

	// directed frames; a typed row carries its result, the rest go through the predictor
	// cr is written as octal 015
	localparam int N_DIR = 20;
	string dir_text [N_DIR] = '{
		"\n",                           // lone lf
		"0000000b\015\n",               // zero count never captures
		"00000A0b\015\n",               // capture frame on channel 1
		"0000140b\015\n",
		"C000000d\015\n",               // capture frame on channel 2
		"0000000d\015\n",               // negative relative force
		"abcdef0b\015\n",               // lower case digits
		"12G4560b\015\n",               // bad hex digit
		"12G4560x\015\n",               // bad tag wins over bad digit
		"1234560b\n",                   // lf one byte early
		"1234560b\015\015\n",           // one byte too many
		"1234561b\015\n",               // bad filler digit
		"1234560bX\n",                  // cr missing
		"1234560d\015\015\015\015\015\015\015\015\n", // long overrun, position holds at limit
		"ABCDEF0d\015\n",               // upper case digits
		"9a8B7c0b\015\n",               // mixed case
		"abcdef0B\015\n",               // tag is case sensitive
		"\015\n",                       // early lf with bad digit too
		"0000010b\015\n",
		"FFFFFF0b\015\n"
	};
	bit dir_typed [N_DIR] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 1, 1, 0, 0};
	result_t dir_result [N_DIR] = '{
		'{ST_FRAME, CH_NONE, 24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_OK,    CH_1,    24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_OK,    CH_1,    24'h00000A, 32'h0000000A, 32'h0,      1'b1},
		'{ST_OK,    CH_1,    24'h000014, 32'h00000014, 32'h0000000A, 1'b0},
		'{ST_OK,    CH_2,    24'hC00000, 32'h00C00000, 32'h0,      1'b1},
		'{ST_OK,    CH_2,    24'h0,      32'h0,      32'hFF400000, 1'b0},
		'{ST_OK,    CH_1,    24'hABCDEF, 32'h00ABCDEF, 32'h00ABCDE5, 1'b0},
		'{ST_HEX,   CH_1,    24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_NONE, 24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_1,    24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_1,    24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_1,    24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_1,    24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_2,    24'h0,      32'h0,      32'h0,        1'b0},
		'0,
		'0,
		'{ST_FRAME, CH_NONE, 24'h0,      32'h0,      32'h0,        1'b0},
		'{ST_FRAME, CH_NONE, 24'h0,      32'h0,      32'h0,        1'b0},
		'0,
		'0
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// advance the shadow parser by one accepted byte; an lf owes one result
	function automatic void parse_rx_byte(input logic [7:0] b, input bit typed,
			input result_t typed_res);
		logic [4:0]  d;
		result_t     r;
		logic [63:0] prod;
		logic [63:0] mag;
		longint      diff;
		logic [23:0] sens;
		int          k;
		if (b != ASC_LF) begin
			if (pr_pos < POS_ZERO) begin
				if (b >= ASC_ZERO && b <= ASC_NINE)
					d = 5'(b - ASC_ZERO);
				else if (b >= ASC_LA && b <= ASC_LF_HI)
					d = 5'(b - ASC_LA + 8'd10);
				else if (b >= ASC_UA && b <= ASC_UF)
					d = 5'(b - ASC_UA + 8'd10);
				else
					d = 5'd16;
				if (d[4])
					pr_herr = 1'b1;
				else
					pr_acc = {pr_acc[19:0], d[3:0]};
			end else if (pr_pos == POS_ZERO) begin
				if (b != ASC_ZERO)
					pr_ferr = 1'b1;
			end else if (pr_pos == POS_TAG) begin
				if (b == ASC_TAG1)
					pr_tag = CH_1;
				else if (b == ASC_TAG2)
					pr_tag = CH_2;
				else
					pr_ferr = 1'b1;
			end else if (pr_pos == POS_CR) begin
				if (b != ASC_CR)
					pr_ferr = 1'b1;
			end else begin
				pr_ferr = 1'b1;
			end
			if (pr_pos < FRAME_END)
				pr_pos = pr_pos + 4'd1;
			return;
		end

		r = '0;
		r.channel = pr_tag;
		// framing and tag faults take precedence over digit faults
		if (pr_pos != FRAME_END || pr_ferr || pr_tag == CH_NONE)
			r.status = ST_FRAME;
		else if (pr_herr)
			r.status = ST_HEX;
		else
			r.status = ST_OK;

		if (r.status == ST_OK) begin
			k = (pr_tag == CH_2) ? 1 : 0;
			sens = sens_of[k];
			r.raw = pr_acc;
			// reference is taken before the forces, so the capturing frame reads zero
			if (!pr_taken[k] && pr_acc != 24'd0) begin
				pr_ref[k] = pr_acc;
				pr_taken[k] = 1'b1;
				r.cap = 1'b1;
			end
			prod = (64'(pr_acc) * 64'(sens)) >> 16;
			r.abs_force = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
			diff = longint'(pr_acc) - longint'(pr_ref[k]);
			if (diff >= 0) begin
				mag = (64'(diff) * 64'(sens)) >> 16;
				r.rel_force = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
			end else begin
				mag = (64'(-diff) * 64'(sens)) >> 16;
				if (mag > 64'h8000_0000)
					mag = 64'h8000_0000;
				r.rel_force = 32'(64'd0 - mag);
			end
		end
		results_due.push_back(typed ? typed_res : r);

		pr_pos  = '0;
		pr_acc  = '0;
		pr_herr = 1'b0;
		pr_ferr = 1'b0;
		pr_tag  = CH_NONE;
	endfunction

	// one byte beat; valid stays high afterwards so back-to-back beats need no toggle
	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_res);
		int n;
		if ($urandom_range(0, 63) == 0)
			src_quiet = !src_quiet;
		n = src_quiet ? 0 : pick_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_rx_byte(b, typed, typed_res);
	endtask

	// random frame: mostly well formed, some damaged, some plain noise
	task automatic send_random_frame(output int count);
		logic [7:0]  q [$];
		logic [23:0] raw;
		logic [3:0]  nib;
		int          kind;
		int          at;
		int          pick;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			raw = 24'($urandom_range(0, 3));
		else if (pick == 1)
			raw = 24'hFFFFFF;
		else
			raw = 24'($urandom);
		for (int i = 5; i >= 0; i--) begin
			nib = raw[i*4 +: 4];
			if (nib < 4'd10)
				q.push_back(ASC_ZERO + 8'(nib));
			else
				q.push_back(($urandom_range(0, 1) ? ASC_UA : ASC_LA) + 8'(nib) - 8'd10);
		end
		q.push_back(ASC_ZERO);
		q.push_back($urandom_range(0, 1) ? ASC_TAG1 : ASC_TAG2);
		q.push_back(ASC_CR);
		q.push_back(ASC_LF);
		if (kind >= 90) begin
			// noise bytes, sometimes closed by an lf
			q.delete();
			repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				q.push_back(ASC_LF);
		end else if (kind >= 75) begin
			// one byte replaced, dropped or inserted ahead of the lf
			at = $urandom_range(0, 8);
			case ($urandom_range(0, 2))
				0: begin
					q[at] = 8'($urandom_range(0, 255));
				end
				1: begin
					q.delete(at);
				end
				default: begin
					q.insert(at, 8'($urandom_range(0, 255)));
				end
			endcase
		end
		foreach (q[i])
			send_byte(q[i], 1'b0, '0);
		count = q.size();
	endtask

	// both sensitivities written back to back, valid held high across them
	task automatic write_sens(input logic [23:0] v1, input logic [23:0] v2);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SENS_CH1;
		cfg_data  <= v1;
		do @(posedge clk); while (!cfg_ready);
		sens_of[CFG_SENS_CH1] = v1;
		cfg_index <= CFG_SENS_CH2;
		cfg_data  <= v2;
		do @(posedge clk); while (!cfg_ready);
		sens_of[CFG_SENS_CH2] = v2;
		cfg_valid <= 1'b0;
	endtask

	// stop sending, wait for every owed result, then let the three stages empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// result side back-pressure
	initial begin : result_sink
		int hold;
		int g;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				snk_quiet = !snk_quiet;
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				g = snk_quiet ? 0 : pick_gap();
				if (g > 0) begin
					hold = g - 1;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// compare each result beat with the oldest owed result
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[1:0], m_tuser[3:2], m_tdata[23:0], m_tdata[55:24],
				m_tdata[87:56], m_tdata[88]};
			if (results_due.size() == 0) begin
				$error("result beat with no frame owed: tuser %h tdata %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (got.status !== want.status) begin
					$error("frame_status expected %0d got %0d", want.status, got.status);
					mismatches++;
				end
				if (got.channel !== want.channel) begin
					$error("channel expected %0d got %0d", want.channel, got.channel);
					mismatches++;
				end
				if (got.raw !== want.raw) begin
					$error("raw_value expected %h got %h", want.raw, got.raw);
					mismatches++;
				end
				if (got.abs_force !== want.abs_force) begin
					$error("absolute_force expected %h got %h", want.abs_force, got.abs_force);
					mismatches++;
				end
				if (got.rel_force !== want.rel_force) begin
					$error("relative_force expected %0d got %0d",
						$signed(want.rel_force), $signed(got.rel_force));
					mismatches++;
				end
				if (got.cap !== want.cap) begin
					$error("zero_captured expected %0d got %0d", want.cap, got.cap);
					mismatches++;
				end
			end
		end
	end

	// main sequence: reset, directed frames, then random frames under several gain settings
	initial begin : byte_source
		int          sent;
		int          n;
		logic [23:0] s1;
		logic [23:0] s2;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SENS_CH1;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset sensitivity, references still free
		for (int i = 0; i < N_DIR; i++)
			for (int j = 0; j < dir_text[i].len(); j++)
				send_byte(dir_text[i][j], dir_typed[i], dir_result[i]);

		// gain phases: both extremes, zero gain on channel 1, then random gains
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin
					s1 = 24'hFFFFFF;
					s2 = 24'hFFFFFF;
				end
				1: begin
					s1 = 24'd1;
					s2 = 24'd1;
				end
				2: begin
					s1 = 24'd0;
					s2 = SENS_RESET;
				end
				default: begin
					s1 = 24'($urandom_range(1, 24'hFFFFFF));
					s2 = 24'($urandom_range(1, 24'hFFFFFF));
				end
			endcase
			write_sens(s1, s2);
			sent = 0;
			while (sent < 150) begin
				send_random_frame(n);
				sent += n;
			end
		end

		drain();
		if (mismatches == 0 && results_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ffpt_pkg.sv
src/ffpt_parser.sv
src/ffpt_scale.sv
src/force_frame_parser_tare_top.sv
sim/tb_force_frame_parser_tare_top.sv
